// File: hdl/hmbd_pkg.sv
// Shared types and constants for the handheld memory bus decoder.
package hmbd_pkg;

  // Access codes carried on the command field.
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // Register addresses with special behaviour on the bus.
  localparam logic [15:0] AddrJoypad   = 16'hFF00;
  localparam logic [15:0] AddrDiv      = 16'hFF04;
  localparam logic [15:0] AddrIrqFlags = 16'hFF0F;
  localparam logic [15:0] AddrDma      = 16'hFF46;
  localparam logic [15:0] AddrWramBank = 16'hFF70;
  localparam logic [15:0] AddrIrqEn    = 16'hFFFF;

  // Low nibble that enables the cartridge RAM.
  localparam logic [3:0]  RamEnableKey = 4'hA;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic quot;
    logic exec;
    logic load;
  } hmbd_cmd_t;

endpackage

// File: hdl/hmbd_ctrl.sv
// Controller that sequences one item through capture, address, access and result load.
module hmbd_ctrl
  import hmbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hmbd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StQuot,
    StExec,
    StLoad
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == StLoad) && (!out_valid_q || out_ready_i);

  assign cmd_o.capture = (state_q == StIdle) && in_valid_i;
  assign cmd_o.quot    = (state_q == StQuot);
  assign cmd_o.exec    = (state_q == StExec);
  assign cmd_o.load    = load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StQuot;
        end
      end
      StQuot: state_d = StExec;
      StExec: state_d = StLoad;
      StLoad: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/hmbd_datapath.sv
// Datapath with the address decoder, bank registers, internal memories and result registers.
module hmbd_datapath
  import hmbd_pkg::*;
#(
  parameter int ROM_BANK_BITS  = 5,
  parameter int WRAM_BANKS     = 8,
  parameter int CART_RAM_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hmbd_cmd_t   cmd_i,
  input  logic        command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  joypad_value_i,
  output logic [7:0]  read_data_o,
  output logic        rom_access_o,
  output logic [18:0] rom_address_o,
  output logic        joypad_write_o,
  output logic        dma_start_o
);

  localparam int WramDepth = WRAM_BANKS * 4096;
  localparam int WramIdxW  = $clog2(WramDepth);
  localparam int CartIdxW  = (CART_RAM_BYTES > 1) ? $clog2(CART_RAM_BYTES) : 1;
  localparam logic [26:0] CartRecip = 27'((64'd1 << 26) / CART_RAM_BYTES);
  localparam logic [13:0] CartLen   = 14'(CART_RAM_BYTES);
  localparam logic [3:0]  WramLen   = 4'(WRAM_BANKS);

  typedef enum logic [3:0] {
    RgRomLo,
    RgRomHi,
    RgVram,
    RgCart,
    RgWramLo,
    RgWramHi,
    RgOam,
    RgUnused,
    RgIo,
    RgHram,
    RgIrqEn
  } region_e;

  function automatic logic [2:0] bank_mod(input logic [2:0] b);
    logic [2:0] v;
    v = b;
    for (int i = 0; i < 8; i++) begin
      if ({1'b0, v} >= WramLen) begin
        v = 3'({1'b0, v} - WramLen);
      end
    end
    return v;
  endfunction

  // Captured item.
  logic        cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [7:0]  joy_q;

  // Bank and control registers.
  logic [ROM_BANK_BITS-1:0] rom_bank_q;
  logic                     ext_ram_en_q;
  logic [2:0]               wram_bank_q;
  logic [7:0]               irq_flags_q;
  logic [7:0]               irq_enable_q;
  logic [127:0]             io_vld_q;

  // Memories and their registered read data.
  logic [7:0] vram_mem [8192];
  logic [7:0] cart_mem [CART_RAM_BYTES];
  logic [7:0] wlo_mem  [4096];
  logic [7:0] whi_mem  [WramDepth];
  logic [7:0] oam_mem  [160];
  logic [7:0] io_mem   [128];
  logic [7:0] hram_mem [127];
  logic [7:0] vram_rd_q, cart_rd_q, wlo_rd_q, whi_rd_q, oam_rd_q, io_rd_q, hram_rd_q;
  logic       io_vld_rd_q;

  // Cartridge RAM offset reduction.
  logic [12:0] cart_off;
  logic [39:0] quot_prod;
  logic [12:0] quot_q;
  logic [26:0] back_prod;
  logic [13:0] rem_raw, rem;
  logic [CartIdxW-1:0] cart_idx;

  // Output registers.
  logic [7:0]  rd_q;
  logic        rom_acc_q;
  logic [18:0] rom_addr_q;
  logic        joy_wr_q;
  logic        dma_q;

  region_e             region;
  logic                is_write;
  logic [WramIdxW-1:0] whi_idx;
  logic [ROM_BANK_BITS-1:0] bank_w;
  logic                io_we;
  logic [7:0]          io_wdata;
  logic [7:0]          rd_d;
  logic [18:0]         rom_addr_d;
  logic                rom_acc_d, joy_wr_d, dma_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      joy_q   <= joypad_value_i;
    end
  end

  always_comb begin
    region = RgUnused;
    unique case (addr_q[15:12]) inside
      [4'h0:4'h3]: region = RgRomLo;
      [4'h4:4'h7]: region = RgRomHi;
      4'h8, 4'h9:  region = RgVram;
      4'hA, 4'hB:  region = RgCart;
      4'hC, 4'hE:  region = RgWramLo;
      4'hD:        region = RgWramHi;
      default: begin
        if (addr_q <= 16'hFDFF) begin
          region = RgWramHi;
        end else if (addr_q <= 16'hFE9F) begin
          region = RgOam;
        end else if (addr_q <= 16'hFEFF) begin
          region = RgUnused;
        end else if (addr_q <= 16'hFF7F) begin
          region = RgIo;
        end else if (addr_q <= 16'hFFFE) begin
          region = RgHram;
        end else begin
          region = RgIrqEn;
        end
      end
    endcase
  end

  assign is_write = cmd_i.exec && (cmd_q == CmdWrite);

  // Offset modulo the cartridge RAM size by reciprocal multiplication.
  assign cart_off  = addr_q[12:0];
  assign quot_prod = 40'(cart_off) * 40'(CartRecip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.quot) begin
      quot_q <= quot_prod[38:26];
    end
  end

  assign back_prod = 27'(quot_q) * 27'(CartLen);
  assign rem_raw   = {1'b0, cart_off} - back_prod[13:0];
  assign rem       = (rem_raw >= CartLen) ? (rem_raw - CartLen) : rem_raw;
  assign cart_idx  = rem[CartIdxW-1:0];

  assign whi_idx = WramIdxW'({bank_mod(wram_bank_q), addr_q[11:0]});
  assign bank_w  = wdata_q[ROM_BANK_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q   <= ROM_BANK_BITS'(1);
      ext_ram_en_q <= 1'b0;
      wram_bank_q  <= 3'd1;
      irq_flags_q  <= 8'h00;
      irq_enable_q <= 8'h00;
      io_vld_q     <= '0;
    end else if (is_write) begin
      if (region == RgRomLo) begin
        if (addr_q[13] == 1'b0) begin
          ext_ram_en_q <= (wdata_q[3:0] == RamEnableKey);
        end else begin
          rom_bank_q <= (bank_w == '0) ? ROM_BANK_BITS'(1) : bank_w;
        end
      end
      if (region == RgIo && addr_q == AddrIrqFlags) begin
        irq_flags_q <= wdata_q;
      end
      if (region == RgIo && addr_q == AddrWramBank) begin
        wram_bank_q <= wdata_q[2:0];
      end
      if (region == RgIrqEn) begin
        irq_enable_q <= wdata_q;
      end
      if (io_we) begin
        io_vld_q[addr_q[6:0]] <= 1'b1;
      end
    end
  end

  assign io_we = is_write && (region == RgIo) && (addr_q != AddrJoypad)
                 && (addr_q != AddrIrqFlags) && (addr_q != AddrWramBank);
  assign io_wdata = (addr_q == AddrDiv) ? 8'h00 : wdata_q;

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgVram) begin
      vram_mem[addr_q[12:0]] <= wdata_q;
    end
    if (cmd_i.exec) begin
      vram_rd_q <= vram_mem[addr_q[12:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgCart && ext_ram_en_q) begin
      cart_mem[cart_idx] <= wdata_q;
    end
    if (cmd_i.exec) begin
      cart_rd_q <= cart_mem[cart_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgWramLo) begin
      wlo_mem[addr_q[11:0]] <= wdata_q;
    end
    if (cmd_i.exec) begin
      wlo_rd_q <= wlo_mem[addr_q[11:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgWramHi) begin
      whi_mem[whi_idx] <= wdata_q;
    end
    if (cmd_i.exec) begin
      whi_rd_q <= whi_mem[whi_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgOam) begin
      oam_mem[addr_q[7:0]] <= wdata_q;
    end
    if (cmd_i.exec) begin
      oam_rd_q <= oam_mem[addr_q[7:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (io_we) begin
      io_mem[addr_q[6:0]] <= io_wdata;
    end
    if (cmd_i.exec) begin
      io_rd_q     <= io_mem[addr_q[6:0]];
      io_vld_rd_q <= io_vld_q[addr_q[6:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write && region == RgHram) begin
      hram_mem[addr_q[6:0]] <= wdata_q;
    end
    if (cmd_i.exec) begin
      hram_rd_q <= hram_mem[addr_q[6:0]];
    end
  end

  always_comb begin
    rd_d       = 8'h00;
    rom_acc_d  = 1'b0;
    rom_addr_d = 19'd0;
    joy_wr_d   = 1'b0;
    dma_d      = 1'b0;
    if (cmd_q == CmdRead) begin
      case (region)
        RgRomLo: begin
          rom_acc_d  = 1'b1;
          rom_addr_d = 19'(addr_q[13:0]);
        end
        RgRomHi: begin
          rom_acc_d  = 1'b1;
          rom_addr_d = 19'({rom_bank_q, addr_q[13:0]});
        end
        RgVram:   rd_d = vram_rd_q;
        RgCart:   rd_d = ext_ram_en_q ? cart_rd_q : 8'hFF;
        RgWramLo: rd_d = wlo_rd_q;
        RgWramHi: rd_d = whi_rd_q;
        RgOam:    rd_d = oam_rd_q;
        RgIo: begin
          if (addr_q == AddrJoypad) begin
            rd_d = joy_q;
          end else if (addr_q == AddrIrqFlags) begin
            rd_d = irq_flags_q;
          end else begin
            rd_d = io_vld_rd_q ? io_rd_q : 8'h00;
          end
        end
        RgHram:   rd_d = hram_rd_q;
        RgIrqEn:  rd_d = irq_enable_q;
        default:  rd_d = 8'h00;
      endcase
    end else begin
      joy_wr_d = (region == RgIo) && (addr_q == AddrJoypad);
      dma_d    = (region == RgIo) && (addr_q == AddrDma);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q       <= rd_d;
      rom_acc_q  <= rom_acc_d;
      rom_addr_q <= rom_addr_d;
      joy_wr_q   <= joy_wr_d;
      dma_q      <= dma_d;
    end
  end

  assign read_data_o    = rd_q;
  assign rom_access_o   = rom_acc_q;
  assign rom_address_o  = rom_addr_q;
  assign joypad_write_o = joy_wr_q;
  assign dma_start_o    = dma_q;

endmodule

// File: hdl/handheld_memory_bus_decoder_core.sv
// Top level of the handheld memory bus decoder with an MBC1-style cartridge mapper.
// Each item is one byte read or write at a 16-bit CPU address. Cartridge ROM is
// external, so a ROM read returns the physical ROM byte address and a zero byte;
// video RAM, cartridge RAM, work RAM, sprite table, I/O registers, high RAM and the
// interrupt registers are held inside. After an item is accepted, a reciprocal
// multiply reduces the cartridge RAM offset, the single-port memory arrays are
// accessed and the result is loaded. A new item is accepted only once the previous
// one has reached the output register, and a result that the result side has not
// taken holds the next one back. No clearing pass is needed after reset; reads of
// memory arrays never written return undefined data, while unwritten I/O register
// locations read as zero.
module handheld_memory_bus_decoder_core
  import hmbd_pkg::*;
#(
  parameter int ROM_BANK_BITS  = 5,
  parameter int WRAM_BANKS     = 8,
  parameter int CART_RAM_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  joypad_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        rom_access_o,
  output logic [18:0] rom_address_o,
  output logic        joypad_write_o,
  output logic        dma_start_o
);

  hmbd_cmd_t cmd;

  hmbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hmbd_datapath #(
    .ROM_BANK_BITS  (ROM_BANK_BITS),
    .WRAM_BANKS     (WRAM_BANKS),
    .CART_RAM_BYTES (CART_RAM_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .command_i      (command_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .joypad_value_i (joypad_value_i),
    .read_data_o    (read_data_o),
    .rom_access_o   (rom_access_o),
    .rom_address_o  (rom_address_o),
    .joypad_write_o (joypad_write_o),
    .dma_start_o    (dma_start_o)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the handheld memory bus decoder core.
module tb
  import hmbd_pkg::*;
();

  typedef enum {
    RgRom0, RgRomX, RgVram, RgCart, RgWram0, RgWramX, RgOam, RgUnused, RgIo, RgHram, RgIe
  } region_e;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_access;
    logic [18:0] rom_address;
    logic        joypad_write;
    logic        dma_start;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  joypad_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        rom_access;
  logic [18:0] rom_address;
  logic        joypad_write;
  logic        dma_start;

  // Shadow of the decoder state.
  logic [4:0] bank_sel = 5'd1;
  logic       ram_on = 1'b0;
  logic [2:0] wram_sel = 3'd1;
  logic [7:0] if_reg = 8'h00;
  logic [7:0] ie_reg = 8'h00;
  logic [7:0] vram_mem [8192];
  logic [7:0] cram_mem [8192];
  logic [7:0] wlow_mem [4096];
  logic [7:0] wbank_mem [32768];
  logic [7:0] oam_mem [160];
  logic [7:0] hram_mem [127];
  bit [7:0]   io_mem [128];
  bit         vram_set [8192];
  bit         cram_set [8192];
  bit         wlow_set [4096];
  bit         wbank_set [32768];
  bit         oam_set [160];
  bit         hram_set [127];

  bus_result_t pending_results [$];
  logic [15:0] recently_written [$];

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int next_gap = 1;
  int hold_cycles = 0;
  int errors = 0;
  int results_seen = 0;
  int reads_sent = 0;
  int writes_sent = 0;
  int rom_reads = 0;
  int dma_starts = 0;
  int joypad_writes = 0;

  handheld_memory_bus_decoder_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .address_i      (address),
    .write_data_i   (write_data),
    .joypad_value_i (joypad_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_data_o    (read_data),
    .rom_access_o   (rom_access),
    .rom_address_o  (rom_address),
    .joypad_write_o (joypad_write),
    .dma_start_o    (dma_start)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic region_e locate(input logic [15:0] a, output int idx);
    region_e rg;
    idx = 0;
    if (a < 16'h4000) begin
      rg = RgRom0;
    end else if (a < 16'h8000) begin
      rg = RgRomX;
    end else if (a < 16'hA000) begin
      rg = RgVram;
      idx = int'(a) - 'h8000;
    end else if (a < 16'hC000) begin
      rg = RgCart;
      idx = int'(a) - 'hA000;
    end else if (a < 16'hD000) begin
      rg = RgWram0;
      idx = int'(a[11:0]);
    end else if (a < 16'hE000) begin
      rg = RgWramX;
      idx = int'(wram_sel) * 4096 + int'(a[11:0]);
    end else if (a < 16'hF000) begin
      rg = RgWram0;
      idx = int'(a[11:0]);
    end else if (a < 16'hFE00) begin
      rg = RgWramX;
      idx = int'(wram_sel) * 4096 + int'(a[11:0]);
    end else if (a < 16'hFEA0) begin
      rg = RgOam;
      idx = int'(a) - 'hFE00;
    end else if (a < 16'hFF00) begin
      rg = RgUnused;
    end else if (a < 16'hFF80) begin
      rg = RgIo;
      idx = int'(a[6:0]);
    end else if (a < 16'hFFFF) begin
      rg = RgHram;
      idx = int'(a) - 'hFF80;
    end else begin
      rg = RgIe;
    end
    return rg;
  endfunction

  function automatic bit unwritten_read(input logic [15:0] a);
    int idx;
    bit miss;
    miss = 1'b0;
    case (locate(a, idx))
      RgVram:  miss = !vram_set[idx];
      RgCart:  miss = ram_on && !cram_set[idx];
      RgWram0: miss = !wlow_set[idx];
      RgWramX: miss = !wbank_set[idx];
      RgOam:   miss = !oam_set[idx];
      RgHram:  miss = !hram_set[idx];
      default: miss = 1'b0;
    endcase
    return miss;
  endfunction

  // Works out the result of one access and updates the shadow state.
  function automatic bus_result_t decode_access(input logic cmd, input logic [15:0] a,
                                                input logic [7:0] v, input logic [7:0] joy);
    bus_result_t r;
    region_e rg;
    int idx;
    r = '0;
    rg = locate(a, idx);
    if (cmd == CmdRead) begin
      case (rg)
        RgRom0: begin
          r.rom_access = 1'b1;
          r.rom_address = {3'b000, a};
        end
        RgRomX: begin
          r.rom_access = 1'b1;
          r.rom_address = {bank_sel, a[13:0]};
        end
        RgVram:  r.read_data = vram_mem[idx];
        RgCart:  r.read_data = ram_on ? cram_mem[idx] : 8'hFF;
        RgWram0: r.read_data = wlow_mem[idx];
        RgWramX: r.read_data = wbank_mem[idx];
        RgOam:   r.read_data = oam_mem[idx];
        RgUnused: r.read_data = 8'h00;
        RgIo: begin
          if (a == AddrJoypad) r.read_data = joy;
          else if (a == AddrIrqFlags) r.read_data = if_reg;
          else r.read_data = io_mem[idx];
        end
        RgHram:  r.read_data = hram_mem[idx];
        default: r.read_data = ie_reg;
      endcase
    end else begin
      recently_written.push_back(a);
      if (recently_written.size() > 64) void'(recently_written.pop_front());
      case (rg)
        RgRom0: begin
          if (a < 16'h2000) ram_on = (v[3:0] == RamEnableKey);
          else bank_sel = (v[4:0] == 5'd0) ? 5'd1 : v[4:0];
        end
        RgRomX: ;
        RgVram: begin
          vram_mem[idx] = v;
          vram_set[idx] = 1'b1;
        end
        RgCart: begin
          if (ram_on) begin
            cram_mem[idx] = v;
            cram_set[idx] = 1'b1;
          end
        end
        RgWram0: begin
          wlow_mem[idx] = v;
          wlow_set[idx] = 1'b1;
        end
        RgWramX: begin
          wbank_mem[idx] = v;
          wbank_set[idx] = 1'b1;
        end
        RgOam: begin
          oam_mem[idx] = v;
          oam_set[idx] = 1'b1;
        end
        RgUnused: ;
        RgIo: begin
          if (a == AddrJoypad) begin
            r.joypad_write = 1'b1;
          end else if (a == AddrDiv) begin
            io_mem[idx] = 8'h00;
          end else if (a == AddrIrqFlags) begin
            if_reg = v;
          end else if (a == AddrWramBank) begin
            wram_sel = v[2:0];
          end else begin
            io_mem[idx] = v;
            r.dma_start = (a == AddrDma);
          end
        end
        RgHram: begin
          hram_mem[idx] = v;
          hram_set[idx] = 1'b1;
        end
        default: ie_reg = v;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_address();
    logic [15:0] a;
    case ($urandom_range(0, 15))
      0:  a = 16'($urandom_range(0, 16'hFFFF));
      1:  a = 16'($urandom_range(0, 16'h1FFF));
      2:  a = 16'($urandom_range(16'h2000, 16'h3FFF));
      3, 4: a = 16'($urandom_range(0, 16'h7FFF));
      5:  a = 16'($urandom_range(16'h8000, 16'h9FFF));
      6:  a = 16'($urandom_range(16'hA000, 16'hBFFF));
      7:  a = 16'($urandom_range(16'hC000, 16'hDFFF));
      8:  a = 16'($urandom_range(16'hE000, 16'hFDFF));
      9:  a = 16'($urandom_range(16'hFE00, 16'hFEFF));
      10: a = 16'($urandom_range(16'hFF00, 16'hFF7F));
      11: begin
        case ($urandom_range(0, 5))
          0: a = AddrJoypad;
          1: a = AddrDiv;
          2: a = AddrIrqFlags;
          3: a = AddrDma;
          4: a = AddrWramBank;
          default: a = AddrIrqEn;
        endcase
      end
      12: a = 16'($urandom_range(16'hFF80, 16'hFFFF));
      default: begin
        if (recently_written.size() > 0)
          a = recently_written[$urandom_range(0, recently_written.size() - 1)];
        else
          a = 16'($urandom_range(0, 16'hFFFF));
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             what, results_seen, got, want);
  endtask

  task automatic send_access(input logic cmd, input logic [15:0] a, input logic [7:0] v,
                             input logic [7:0] joy);
    bus_result_t want;
    repeat ((next_gap > 0) ? next_gap : 1) @(negedge clk);
    command <= cmd;
    address <= a;
    write_data <= v;
    joypad_value <= joy;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = decode_access(cmd, a, v, joy);
    pending_results.push_back(want);
    if (cmd == CmdRead) reads_sent++;
    else writes_sent++;
    if (want.rom_access) rom_reads++;
    if (want.dma_start) dma_starts++;
    if (want.joypad_write) joypad_writes++;
    next_gap = send_idle ? int'($urandom_range(0, 13)) : 0;
    if (next_gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_random();
    logic        cmd;
    logic [15:0] a;
    logic [7:0]  v;
    a = pick_address();
    v = 8'($urandom_range(0, 255));
    cmd = ($urandom_range(0, 2) == 0) ? CmdWrite : CmdRead;
    if (a < 16'h2000 && $urandom_range(0, 1) == 1) v[3:0] = RamEnableKey;
    if (cmd == CmdRead && unwritten_read(a)) cmd = CmdWrite;
    send_access(cmd, a, v, 8'($urandom_range(0, 255)));
  endtask

  task automatic pause_input();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    next_gap = 1;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_access(CmdWrite, 16'h2000, 8'hE0, 8'h00);
    send_access(CmdWrite, 16'h3FFF, 8'hFF, 8'h00);
    send_access(CmdRead,  16'h7FFF, 8'h00, 8'h00);
    send_access(CmdWrite, 16'h6000, 8'h00, 8'h00);
    send_access(CmdRead,  16'h4000, 8'h00, 8'h00);
    send_access(CmdRead,  16'hBFFF, 8'h00, 8'h00);
    send_access(CmdWrite, 16'hA000, 8'h11, 8'h00);
    send_access(CmdWrite, 16'h1FFF, 8'hFA, 8'h00);
    send_access(CmdWrite, 16'hBFFF, 8'h5A, 8'h00);
    send_access(CmdRead,  16'hBFFF, 8'h00, 8'h00);
    send_access(CmdWrite, 16'h0000, 8'h0B, 8'h00);
    send_access(CmdRead,  16'hBFFF, 8'h00, 8'h00);
    send_access(CmdWrite, 16'hEFFF, 8'hC3, 8'h00);
    send_access(CmdRead,  16'hCFFF, 8'h00, 8'h00);
    send_access(CmdWrite, AddrWramBank, 8'hF8, 8'h00);
    send_access(CmdWrite, 16'hFDFF, 8'h3C, 8'h00);
    send_access(CmdRead,  16'hDDFF, 8'h00, 8'h00);
    send_access(CmdRead,  16'hFEFF, 8'h00, 8'h00);
    send_access(CmdWrite, AddrJoypad, 8'h30, 8'h00);
    send_access(CmdRead,  AddrJoypad, 8'h00, 8'hFF);
    send_access(CmdWrite, AddrDiv, 8'hFF, 8'h00);
    send_access(CmdRead,  AddrDiv, 8'h00, 8'h00);
    send_access(CmdWrite, AddrDma, 8'hC0, 8'h00);
    send_access(CmdWrite, AddrIrqFlags, 8'h1F, 8'h00);
    send_access(CmdRead,  AddrIrqFlags, 8'h00, 8'h00);
    send_access(CmdWrite, AddrIrqEn, 8'hFF, 8'h00);
    send_access(CmdRead,  AddrIrqEn, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int count);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (count) send_random();
  endtask

  task automatic test_back_to_back(input int count);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    repeat (count) send_random();
  endtask

  task automatic test_output_stall(input int count);
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_cycles = 300;
    repeat (count) send_random();
  endtask

  task automatic test_paused_bursts(input int bursts, input int burst_len);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    repeat (bursts) begin
      repeat (burst_len) send_random();
      pause_input();
      wait_for_results();
    end
  endtask

  initial begin : result_side
    int n;
    forever begin
      n = recv_idle ? int'($urandom_range(0, 13)) : 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      @(negedge clk);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    bus_result_t want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", int'(read_data), 0);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data)
          report_mismatch("read_data", int'(read_data), int'(want.read_data));
        if (rom_access !== want.rom_access)
          report_mismatch("rom_access", int'(rom_access), int'(want.rom_access));
        if (rom_address !== want.rom_address)
          report_mismatch("rom_address", int'(rom_address), int'(want.rom_address));
        if (joypad_write !== want.joypad_write)
          report_mismatch("joypad_write", int'(joypad_write), int'(want.joypad_write));
        if (dma_start !== want.dma_start)
          report_mismatch("dma_start", int'(dma_start), int'(want.dma_start));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = CmdRead;
    address = 16'h0000;
    write_data = 8'h00;
    joypad_value = 8'h00;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(1150);
    test_back_to_back(200);
    test_output_stall(120);
    test_paused_bursts(10, 20);

    pause_input();
    wait_for_results();
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", 0, pending_results.size());

    $display("Sent %0d reads and %0d writes; %0d results checked.",
             reads_sent, writes_sent, results_seen);
    $display("Covered %0d ROM reads, %0d DMA starts and %0d joypad writes.",
             rom_reads, dma_starts, joypad_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
